FILE: hdl/kwm_pkg.sv
// Shared types and constants for the k-way merge engine.
package kwm_pkg;

    // Default sizing of the word store and run table
    localparam int STORE_DEPTH_DEF = 1024;
    localparam int MAX_RUNS_DEF    = 8;

    // Fixed field widths
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 4;

    // Opcodes carried on the slave tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // Master tuser bit positions
    localparam int TUSER_VALID = 0;
    localparam int TUSER_OVF   = 1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_BOUND,
        ST_SCAN,
        ST_EMIT
    } kwm_state_t;

endpackage

FILE: hdl/k_way_merge_engine.sv
// Top level of the k-way merge engine: load buffer, bound sequencer and merge scan.
//
// Loads (tuser opcode 0) append one signed word to the store; a load into a full store
// returns one result with the overflow flag. A pull (opcode 1) returns the smallest
// remaining run head, ties to the lower run: one RAM read port and one comparator visit
// the k run heads one per cycle, k being the latched run count; the registered read data
// returns, the scan closes and updates the winning head, and the output register is
// loaded once any earlier result has been taken; the block is then ready for the next
// item. The first pull of a set adds the run split: a bit-serial divide of the item
// count by k (one bit per cycle) and then a bound accumulation over the k runs. The
// block takes no new item while a pull is at work; a finished result waits in the
// output register, and further items may still be taken then.
// run_count is written through cfg_we/cfg_data; 0 acts as 1 and values above MAX_RUNS
// saturate. After the last word of a set (tlast) the block returns to the loading phase.
module k_way_merge_engine #(
    parameter int STORE_DEPTH = kwm_pkg::STORE_DEPTH_DEF,
    parameter int MAX_RUNS    = kwm_pkg::MAX_RUNS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration: run_count
    input  logic                       cfg_we,
    input  logic [kwm_pkg::CFG_W-1:0]  cfg_data,
    // slave stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,   // [31:0] value
    input  logic                       s_axis_tuser,   // [0] opcode
    // master stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata,   // [31:0] merged_value
    output logic                       m_axis_tlast,   // last
    output logic [1:0]                 m_axis_tuser    // [0] valid_res, [1] overflow
);

    localparam int VW = kwm_pkg::VALUE_W;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int RW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int TW = $clog2(MAX_RUNS + 1);
    localparam int DW = $clog2(CW + 1);

    // Control registers
    kwm_pkg::kwm_state_t        state_reg, state_next;
    logic [kwm_pkg::CFG_W-1:0]  run_count_reg;
    logic                       merging_reg;
    logic [CW-1:0]              item_count_reg;
    logic [CW-1:0]              emitted_reg;
    logic [TW-1:0]              k_reg;
    logic [DW-1:0]              div_cnt_reg;
    logic [TW-1:0]              bt_reg;
    logic [TW-1:0]              scan_cnt_reg;
    logic                       p_valid_reg;
    logic                       found_reg;
    logic                       out_tvalid_reg;

    // Payload registers
    logic [CW-1:0]              run_head_reg [MAX_RUNS];
    logic [CW-1:0]              run_end_reg  [MAX_RUNS];
    logic [CW-1:0]              div_n_reg;
    logic [TW-1:0]              div_rem_reg;
    logic [CW-1:0]              acc_q_reg;
    logic [TW-1:0]              acc_r_reg;
    logic                       p_live_reg;
    logic [RW-1:0]              p_idx_reg;
    logic [RW-1:0]              best_t_reg;
    logic [VW-1:0]              best_v_reg;
    logic [VW-1:0]              res_value_reg;
    logic                       res_valid_reg;
    logic                       res_last_reg;
    logic                       res_ovf_reg;
    logic [VW-1:0]              out_value_reg;
    logic                       out_valid_res_reg;
    logic                       out_last_reg;
    logic                       out_ovf_reg;

    // Combinational control
    logic                       in_fire;
    logic                       is_load;
    logic                       store_full;
    logic                       ram_we;
    logic [AW-1:0]              ram_raddr;
    logic [VW-1:0]              ram_rdata;
    logic                       scan_issue;
    logic                       scan_done;
    logic                       emit_go;
    logic                       div_last;
    logic                       bound_last;
    logic [TW-1:0]              k_eff;
    logic [RW-1:0]              scan_idx;
    logic                       set_last;

    // Divider and bound step arithmetic
    logic [TW:0]                div_trial;
    logic                       div_ge;
    logic [TW-1:0]              div_rem_next;
    logic [TW:0]                bnd_rsum;
    logic                       bnd_carry;
    logic [TW-1:0]              acc_r_next;
    logic [CW-1:0]              acc_q_next;

    kwm_ram #(
        .WIDTH (VW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item_count_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clamp the configured run count to 1..MAX_RUNS
    always_comb
    begin
        if (cfg_data == '0 && run_count_reg == '0)
        begin
            k_eff = TW'(1);
        end
        else if (run_count_reg == '0)
        begin
            k_eff = TW'(1);
        end
        else if (32'(run_count_reg) > MAX_RUNS)
        begin
            k_eff = TW'(MAX_RUNS);
        end
        else
        begin
            k_eff = TW'(run_count_reg);
        end
    end

    // Shared step unit: one divide bit or one bound increment per cycle
    always_comb
    begin
        div_trial    = {div_rem_reg, div_n_reg[CW-1]};
        div_ge       = div_trial >= {1'b0, k_reg};
        div_rem_next = div_ge ? TW'(div_trial - {1'b0, k_reg}) : TW'(div_trial);
        bnd_rsum     = {1'b0, acc_r_reg} + {1'b0, div_rem_reg};
        bnd_carry    = bnd_rsum >= {1'b0, k_reg};
        acc_r_next   = bnd_carry ? TW'(bnd_rsum - {1'b0, k_reg}) : TW'(bnd_rsum);
        acc_q_next   = CW'(acc_q_reg + div_n_reg + CW'(bnd_carry));
    end

    // Output and handshake decode
    always_comb
    begin
        s_axis_tready = (state_reg == kwm_pkg::ST_IDLE);
        in_fire       = s_axis_tvalid && s_axis_tready;
        is_load       = (s_axis_tuser == kwm_pkg::OP_LOAD);
        store_full    = (item_count_reg == CW'(STORE_DEPTH));
        ram_we        = in_fire && is_load && !merging_reg && !store_full;
        scan_idx      = scan_cnt_reg[RW-1:0];
        scan_issue    = (state_reg == kwm_pkg::ST_SCAN) && (scan_cnt_reg < k_reg);
        scan_done     = (state_reg == kwm_pkg::ST_SCAN) && (scan_cnt_reg == k_reg)
                        && !p_valid_reg;
        ram_raddr     = run_head_reg[scan_idx][AW-1:0];
        emit_go       = (state_reg == kwm_pkg::ST_EMIT) && (!out_tvalid_reg || m_axis_tready);
        div_last      = (div_cnt_reg == DW'(CW - 1));
        bound_last    = ({1'b0, bt_reg} + 1'b1) == {1'b0, k_reg};
        set_last      = ({1'b0, emitted_reg} + 1'b1) >= {1'b0, item_count_reg};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kwm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (is_load)
                    begin
                        if (!merging_reg && store_full)
                        begin
                            state_next = kwm_pkg::ST_EMIT;
                        end
                    end
                    else if (merging_reg)
                    begin
                        state_next = kwm_pkg::ST_SCAN;
                    end
                    else if (item_count_reg == '0)
                    begin
                        state_next = kwm_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = kwm_pkg::ST_DIV;
                    end
                end
            end
            kwm_pkg::ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = kwm_pkg::ST_BOUND;
                end
            end
            kwm_pkg::ST_BOUND:
            begin
                if (bound_last)
                begin
                    state_next = kwm_pkg::ST_SCAN;
                end
            end
            kwm_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = kwm_pkg::ST_EMIT;
                end
            end
            kwm_pkg::ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = kwm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kwm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kwm_pkg::ST_IDLE;
            run_count_reg  <= kwm_pkg::CFG_W'(1);
            merging_reg    <= 1'b0;
            item_count_reg <= '0;
            emitted_reg    <= '0;
            k_reg          <= TW'(1);
            div_cnt_reg    <= '0;
            bt_reg         <= '0;
            scan_cnt_reg   <= '0;
            p_valid_reg    <= 1'b0;
            found_reg      <= 1'b0;
            out_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // take the configuration write
            if (cfg_we)
            begin
                run_count_reg <= cfg_data;
            end

            // append a word
            if (ram_we)
            begin
                item_count_reg <= CW'(item_count_reg + 1'b1);
            end

            // start a pull: latch k and arm the divider, or rearm the scan
            if (in_fire && !is_load)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
                if (!merging_reg && item_count_reg != '0)
                begin
                    merging_reg <= 1'b1;
                    emitted_reg <= '0;
                    k_reg       <= k_eff;
                    div_cnt_reg <= '0;
                end
            end

            // advance divider
            if (state_reg == kwm_pkg::ST_DIV)
            begin
                div_cnt_reg <= DW'(div_cnt_reg + 1'b1);
                bt_reg      <= '0;
            end

            // advance bound counter
            if (state_reg == kwm_pkg::ST_BOUND)
            begin
                bt_reg <= TW'(bt_reg + 1'b1);
            end

            // advance scan and track the best head
            if (scan_issue)
            begin
                scan_cnt_reg <= TW'(scan_cnt_reg + 1'b1);
            end
            p_valid_reg <= scan_issue;
            if (p_valid_reg && p_live_reg)
            begin
                if (!found_reg || ($signed(ram_rdata) < $signed(best_v_reg)))
                begin
                    found_reg <= 1'b1;
                end
            end

            // close the scan
            if (scan_done)
            begin
                if (!found_reg)
                begin
                    merging_reg    <= 1'b0;
                    item_count_reg <= '0;
                    emitted_reg    <= '0;
                end
                else if (set_last)
                begin
                    merging_reg    <= 1'b0;
                    item_count_reg <= '0;
                    emitted_reg    <= '0;
                end
                else
                begin
                    emitted_reg <= CW'(emitted_reg + 1'b1);
                end
            end

            // hold or drop the output transfer
            if (emit_go)
            begin
                out_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        // immediate results from the idle state
        if (in_fire)
        begin
            res_value_reg <= '0;
            res_valid_reg <= 1'b0;
            res_last_reg  <= 1'b0;
            res_ovf_reg   <= is_load;
            if (!is_load && !merging_reg)
            begin
                div_n_reg   <= item_count_reg;
                div_rem_reg <= '0;
            end
        end

        // one restoring divide bit
        if (state_reg == kwm_pkg::ST_DIV)
        begin
            div_n_reg   <= {div_n_reg[CW-2:0], div_ge};
            div_rem_reg <= div_rem_next;
            acc_q_reg   <= '0;
            acc_r_reg   <= '0;
        end

        // one run bound: head from the running quotient, end from the next
        if (state_reg == kwm_pkg::ST_BOUND)
        begin
            run_head_reg[bt_reg[RW-1:0]] <= acc_q_reg;
            run_end_reg[bt_reg[RW-1:0]]  <= acc_q_next;
            acc_q_reg                    <= acc_q_next;
            acc_r_reg                    <= acc_r_next;
        end

        // issue one head read
        if (scan_issue)
        begin
            p_idx_reg  <= scan_idx;
            p_live_reg <= run_head_reg[scan_idx] < run_end_reg[scan_idx];
        end

        // compare the returned head with the best so far
        if (p_valid_reg && p_live_reg)
        begin
            if (!found_reg || ($signed(ram_rdata) < $signed(best_v_reg)))
            begin
                best_v_reg <= ram_rdata;
                best_t_reg <= p_idx_reg;
            end
        end

        // form the merge result and advance the winning head
        if (scan_done)
        begin
            res_ovf_reg <= 1'b0;
            if (found_reg)
            begin
                run_head_reg[best_t_reg] <= CW'(run_head_reg[best_t_reg] + 1'b1);
                res_value_reg            <= best_v_reg;
                res_valid_reg            <= 1'b1;
                res_last_reg             <= set_last;
            end
            else
            begin
                res_value_reg <= '0;
                res_valid_reg <= 1'b0;
                res_last_reg  <= 1'b0;
            end
        end

        // load the output register
        if (emit_go)
        begin
            out_value_reg     <= res_value_reg;
            out_valid_res_reg <= res_valid_reg;
            out_last_reg      <= res_last_reg;
            out_ovf_reg       <= res_ovf_reg;
        end
    end

    assign m_axis_tvalid                     = out_tvalid_reg;
    assign m_axis_tdata                      = out_value_reg;
    assign m_axis_tlast                      = out_last_reg;
    assign m_axis_tuser[kwm_pkg::TUSER_VALID] = out_valid_res_reg;
    assign m_axis_tuser[kwm_pkg::TUSER_OVF]   = out_ovf_reg;

    // The fill count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        item_count_reg <= CW'(STORE_DEPTH))
        else $error("item count beyond store depth");

    // While merging, fewer words have gone out than were loaded
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        merging_reg |-> (emitted_reg < item_count_reg))
        else $error("emitted count reached item count while merging");

    // Scan and split only run inside a merge set
    a_scan_merging: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kwm_pkg::ST_SCAN || state_reg == kwm_pkg::ST_BOUND ||
         state_reg == kwm_pkg::ST_DIV) |-> merging_reg)
        else $error("merge sequencer active outside a set");

    // A last result always carries a valid word and never an overflow
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_tvalid_reg && out_last_reg) |-> (out_valid_res_reg && !out_ovf_reg))
        else $error("last flag on a result without a word");

    // The latched run count stays in range
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        merging_reg |-> (k_reg != '0 && 32'(k_reg) <= MAX_RUNS))
        else $error("latched run count out of range");

endmodule

FILE: hdl/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry and register one read each cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
